[rtl/core/cbn_pkg.sv]
// shared types and constants for the corridor band normalizer
`timescale 1ns / 1ps

package cbn_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int VAL_W         = 32;
    localparam int CFG_IDX_W     = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAFE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HARD = 2'd2;

    // reset values of the band edges
    localparam logic signed [VAL_W-1:0] SAFE_RST = 32'sd0;
    localparam logic signed [VAL_W-1:0] GOLD_RST = 32'sd65536;
    localparam logic signed [VAL_W-1:0] HARD_RST = 32'sd131072;

    typedef enum logic [1:0] {
        ZONE_SAFE = 2'd0,
        ZONE_GOLD = 2'd1,
        ZONE_HIGH = 2'd2,
        ZONE_HARD = 2'd3
    } t_zone;

    // side info that rides along the divider stages
    typedef struct packed {
        t_zone zone;
        logic  band_error;
    } t_tag;

endpackage

[rtl/core/corridor_band_normalizer.sv]
// top level of the corridor band normalizer
`timescale 1ns / 1ps

// maps each signed 32-bit sample onto a fraction of its band with FRAC_BITS
// fraction bits (1 << FRAC_BITS means 1.0) and reports the zone: 0 at or below
// the safe edge, 1 up to and including the gold edge, 2 below the hard edge,
// 3 at or above it (fraction 1.0). the gold-to-hard segment restarts at 0.
// edges that are not strictly increasing give band_error with fraction 0 and
// zone 0. one word is taken per clock while the pipeline is not backed up;
// two stages classify the sample and form the operands, then a restoring
// divider resolves one quotient bit per stage over FRAC_BITS + 1 stages,
// each one 34-bit compare-subtract. each stage holds its own valid bit and
// fills bubbles, so input keeps flowing while a result waits at the output
// until every stage is full. write the edge registers only while nothing is
// in flight; a write to index 3 is ignored.

module corridor_band_normalizer
    import cbn_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int QW       = FRAC_BITS + 1,
    localparam int OUT_W    = ((QW + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // edge register write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_data,
    // sample stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [VAL_W-1:0]     s_axis_tdata,  // [31:0] sample_value
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata,  // [QW-1:0] fraction, rest zero
    output logic [2:0]           m_axis_tuser   // [1:0] zone, [2] band_error
);

    localparam int NSTEP = FRAC_BITS + 1;

    logic signed [VAL_W-1:0] r_safe_edge;
    logic signed [VAL_W-1:0] r_gold_edge;
    logic signed [VAL_W-1:0] r_hard_edge;

    // index k feeds division step k, index NSTEP is the output register
    logic             w_valid [0:NSTEP];
    logic             w_ready [0:NSTEP];
    logic [VAL_W-1:0] w_rem   [0:NSTEP];
    logic [VAL_W-1:0] w_den   [0:NSTEP];
    logic [QW-1:0]    w_q     [0:NSTEP];
    t_tag             w_tag   [0:NSTEP];

    // edge registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safe_edge <= SAFE_RST;
            r_gold_edge <= GOLD_RST;
            r_hard_edge <= HARD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SAFE: r_safe_edge <= i_cfg_data;
                REG_GOLD: r_gold_edge <= i_cfg_data;
                REG_HARD: r_hard_edge <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // classify and set up dividend and divisor
    cbn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_sample    (s_axis_tdata),
        .i_safe_edge (r_safe_edge),
        .i_gold_edge (r_gold_edge),
        .i_hard_edge (r_hard_edge),
        .o_valid     (w_valid[0]),
        .i_ready     (w_ready[0]),
        .o_rem       (w_rem[0]),
        .o_den       (w_den[0]),
        .o_tag       (w_tag[0])
    );

    assign w_q[0] = '0;

    // first step takes the integer bit without a shift, the rest shift in
    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        cbn_div_step #(
            .QW    (QW),
            .SHIFT (k != 0)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_rem   (w_rem[k]),
            .i_den   (w_den[k]),
            .i_q     (w_q[k]),
            .i_tag   (w_tag[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_den   (w_den[k+1]),
            .o_q     (w_q[k+1]),
            .o_tag   (w_tag[k+1])
        );
    end

    assign w_ready[NSTEP] = m_axis_tready;

    // last step register drives the result stream directly
    assign m_axis_tvalid = w_valid[NSTEP];
    assign m_axis_tdata  = OUT_W'(w_q[NSTEP]);
    assign m_axis_tuser  = {w_tag[NSTEP].band_error, w_tag[NSTEP].zone};

endmodule

[rtl/core/cbn_front.sv]
// classification and operand setup, two register stages
`timescale 1ns / 1ps

module cbn_front
    import cbn_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [VAL_W-1:0] i_sample,
    input  logic signed [VAL_W-1:0] i_safe_edge,
    input  logic signed [VAL_W-1:0] i_gold_edge,
    input  logic signed [VAL_W-1:0] i_hard_edge,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [VAL_W-1:0]        o_rem,
    output logic [VAL_W-1:0]        o_den,
    output t_tag                    o_tag
);

    logic                    r_a_valid;
    logic signed [VAL_W-1:0] r_a_sample;
    t_tag                    r_a_tag;
    logic                    r_b_valid;
    logic [VAL_W-1:0]        r_b_rem;
    logic [VAL_W-1:0]        r_b_den;
    t_tag                    r_b_tag;

    logic       w_a_ready;
    logic       w_b_ready;
    t_tag       n_a_tag;
    logic [VAL_W-1:0] n_b_rem;
    logic [VAL_W-1:0] n_b_den;
    logic signed [VAL_W-1:0] w_lo;
    logic signed [VAL_W-1:0] w_hi;
    logic [VAL_W:0]   w_num;
    logic [VAL_W:0]   w_span;

    assign w_b_ready = !r_b_valid || i_ready;
    assign w_a_ready = !r_a_valid || w_b_ready;
    assign o_ready   = w_a_ready;

    always_comb begin
        n_a_tag = '{zone: ZONE_SAFE, band_error: 1'b0};
        if (i_hard_edge <= i_gold_edge || i_gold_edge <= i_safe_edge) begin
            n_a_tag.band_error = 1'b1;
        end else if (i_sample <= i_safe_edge) begin
            n_a_tag.zone = ZONE_SAFE;
        end else if (i_sample >= i_hard_edge) begin
            n_a_tag.zone = ZONE_HARD;
        end else if (i_sample <= i_gold_edge) begin
            n_a_tag.zone = ZONE_GOLD;
        end else begin
            n_a_tag.zone = ZONE_HIGH;
        end
    end

    // zone 0 and errors divide 0 by 1, the hard zone 1 by 1 for a full fraction
    always_comb begin
        w_lo = (r_a_tag.zone == ZONE_GOLD) ? i_safe_edge : i_gold_edge;
        w_hi = (r_a_tag.zone == ZONE_GOLD) ? i_gold_edge : i_hard_edge;
        w_num  = {r_a_sample[VAL_W-1], r_a_sample} - {w_lo[VAL_W-1], w_lo};
        w_span = {w_hi[VAL_W-1], w_hi} - {w_lo[VAL_W-1], w_lo};
        n_b_rem = '0;
        n_b_den = VAL_W'(1);
        if (!r_a_tag.band_error) begin
            case (r_a_tag.zone)
                ZONE_GOLD, ZONE_HIGH: begin
                    n_b_rem = w_num[VAL_W-1:0];
                    n_b_den = w_span[VAL_W-1:0];
                end
                ZONE_HARD: begin
                    n_b_rem = VAL_W'(1);
                end
                default: begin
                    n_b_rem = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_valid <= i_valid;
            end
            if (w_b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_ready && i_valid) begin
            r_a_sample <= i_sample;
            r_a_tag    <= n_a_tag;
        end
        if (w_b_ready && r_a_valid) begin
            r_b_rem <= n_b_rem;
            r_b_den <= n_b_den;
            r_b_tag <= r_a_tag;
        end
    end

    assign o_valid = r_b_valid;
    assign o_rem   = r_b_rem;
    assign o_den   = r_b_den;
    assign o_tag   = r_b_tag;

endmodule

[rtl/core/cbn_div_step.sv]
// one restoring division step with its pipeline register
`timescale 1ns / 1ps

module cbn_div_step
    import cbn_pkg::*;
#(
    parameter int QW    = FRAC_BITS_DEF + 1,
    parameter bit SHIFT = 1'b1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [VAL_W-1:0] i_rem,
    input  logic [VAL_W-1:0] i_den,
    input  logic [QW-1:0]    i_q,
    input  t_tag             i_tag,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [VAL_W-1:0] o_rem,
    output logic [VAL_W-1:0] o_den,
    output logic [QW-1:0]    o_q,
    output t_tag             o_tag
);

    logic             r_valid;
    logic [VAL_W-1:0] r_rem;
    logic [VAL_W-1:0] r_den;
    logic [QW-1:0]    r_q;
    t_tag             r_tag;

    logic [VAL_W:0]   w_part;
    logic [VAL_W+1:0] w_diff;
    logic             w_bit;

    assign o_ready = !r_valid || i_ready;

    // partial remainder stays below twice the divisor
    assign w_part = SHIFT ? {i_rem, 1'b0} : {1'b0, i_rem};
    assign w_diff = {1'b0, w_part} - {2'b00, i_den};
    assign w_bit  = !w_diff[VAL_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rem <= w_bit ? w_diff[VAL_W-1:0] : w_part[VAL_W-1:0];
            r_den <= i_den;
            r_q   <= {i_q[QW-2:0], w_bit};
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_q     = r_q;
    assign o_tag   = r_tag;

endmodule

[rtl/core/cbn_checker.sv]
// port-level checks for the corridor band normalizer, bound to the top level
`timescale 1ns / 1ps

module cbn_checker
    import cbn_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int QW       = FRAC_BITS + 1,
    localparam int OUT_W    = ((QW + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic [2:0]       m_axis_tuser
);

    localparam logic [QW-1:0] FULL = QW'(1) << FRAC_BITS;

    logic [QW-1:0] w_frac;
    assign w_frac = m_axis_tdata[QW-1:0];

    // a stalled result word keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> w_frac == '0 && m_axis_tuser[1:0] == 2'd0)
        else $error("band error word carries fraction or zone");

    a_hard_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[2] && m_axis_tuser[1:0] == ZONE_HARD
            |-> w_frac == FULL)
        else $error("hard zone without full fraction");

    a_safe_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == ZONE_SAFE |-> w_frac == '0)
        else $error("safe zone with nonzero fraction");

    // fraction stays at or below 1.0 and pad bits above it stay zero
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_frac <= FULL && (m_axis_tdata >> QW) == '0)
        else $error("fraction out of range");

endmodule

bind corridor_band_normalizer cbn_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_cbn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/sv/tb_corridor_band_normalizer.sv]
// self-checking stream testbench for the corridor band normalizer
`timescale 1ns / 1ps

module tb_corridor_band_normalizer;
    import cbn_pkg::*;

    localparam int QW    = FRAC_BITS_DEF + 1;
    localparam int OUT_W = ((QW + 7) / 8) * 8;

    // index 3 has no register behind it, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam longint VAL_MIN = -64'sd2147483648;
    localparam longint VAL_MAX = 64'sd2147483647;

    // what one result word should carry
    typedef struct packed {
        logic [QW-1:0] fraction;
        t_zone         zone;
        logic          band_error;
    } t_band_word;

    // clock and all block inputs start at known values
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = REG_SAFE;
    logic [VAL_W-1:0]     i_cfg_data = '0;
    logic                 s_tvalid   = 1'b0;
    logic [VAL_W-1:0]     s_tdata    = '0;
    logic                 m_tready   = 1'b0;
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic [2:0]           m_axis_tuser;

    corridor_band_normalizer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),       // [31:0] sample_value
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),  // [16:0] fraction, rest zero
        .m_axis_tuser  (m_axis_tuser)   // [1:0] zone, [2] band_error
    );

    always #5 i_clk = ~i_clk;

    // our own copy of the band edges, follows the write port
    logic signed [VAL_W-1:0] edge_safe = SAFE_RST;
    logic signed [VAL_W-1:0] edge_gold = GOLD_RST;
    logic signed [VAL_W-1:0] edge_hard = HARD_RST;

    logic [VAL_W-1:0] pending_samples[$];  // samples waiting for the driver
    t_band_word       band_expect[$];      // predicted words, oldest first
    logic             sample_taken = 1'b0; // sample word accepted at last rising edge
    int               mismatch_count = 0;
    int               words_out = 0;
    int               random_sent = 0;

    // sender burst shaping
    int burst_left = 8;
    int gap_left   = 0;
    int burst_no   = 0;
    bit draining   = 1'b0;

    // receiver stall pattern
    int ready_mode = 0;
    int mode_left  = 0;

    // expected word for one sample under the current edges
    function automatic t_band_word band_position(input logic signed [VAL_W-1:0] v);
        t_band_word r;
        longint     sv, s, g, h, q;
        sv = longint'(v);
        s  = longint'(edge_safe);
        g  = longint'(edge_gold);
        h  = longint'(edge_hard);
        r  = '{fraction: '0, zone: ZONE_SAFE, band_error: 1'b0};
        q  = 0;
        if (h <= g || g <= s) begin
            // edges out of order: flag only, fraction and zone stay zero
            r.band_error = 1'b1;
        end else if (sv <= s) begin
            r.zone = ZONE_SAFE;
        end else if (sv >= h) begin
            r.zone = ZONE_HARD;
            q      = longint'(1) << FRAC_BITS_DEF;
        end else if (sv <= g) begin
            // gold edge itself lands here with a full 1.0
            r.zone = ZONE_GOLD;
            q      = ((sv - s) << FRAC_BITS_DEF) / (g - s);
        end else begin
            // upper segment starts over from zero
            r.zone = ZONE_HIGH;
            q      = ((sv - g) << FRAC_BITS_DEF) / (h - g);
        end
        r.fraction = q[QW-1:0];
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] clamp_value(input longint x);
        if (x < VAL_MIN) x = VAL_MIN;
        if (x > VAL_MAX) x = VAL_MAX;
        return x[VAL_W-1:0];
    endfunction

    // random sample biased toward the configured bands and their edges
    function automatic logic [VAL_W-1:0] band_sample();
        longint          s, g, h, span, pad, pick;
        longint unsigned r;
        int              k;
        s    = longint'(edge_safe);
        g    = longint'(edge_gold);
        h    = longint'(edge_hard);
        span = h - s;
        k    = $urandom_range(0, 7);
        r    = {$urandom, $urandom};
        if (k <= 1 || span <= 0) begin
            return $urandom;
        end else if (k <= 5) begin
            pad  = span / 8;
            pick = s - pad + longint'(r % longint'(span + 2 * pad + 1));
            return clamp_value(pick);
        end else begin
            case ($urandom_range(0, 2))
                0:       pick = s;
                1:       pick = g;
                default: pick = h;
            endcase
            return clamp_value(pick + $urandom_range(0, 2) - 1);
        end
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        $display("[%0t] word %0d %s: expected %0h, got %0h", $time, words_out, what, want, got);
    endtask

    // one register write, held for a single rising edge
    task automatic write_band_edge(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic write_bands(input logic [VAL_W-1:0] s, g, h);
        write_band_edge(REG_SAFE, s);
        write_band_edge(REG_GOLD, g);
        write_band_edge(REG_HARD, h);
    endtask

    // every sample in has one word out, so an empty prediction queue
    // with nothing offered means the pipeline is empty
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_samples.size() != 0 || s_tvalid || band_expect.size() != 0)
            @(posedge i_clk);
    endtask

    // fresh random edges: mostly ordered bands of mixed widths, some out of order
    task automatic pick_band_edges(output logic [VAL_W-1:0] s, g, h);
        longint base, lo, mid, hi, t;
        int     m;
        m    = $urandom_range(0, 9);
        base = longint'($signed($urandom));
        if (m <= 5) begin
            // narrow bands anywhere in the range
            if (base > VAL_MAX - (longint'(1) << 22))
                base -= longint'(1) << 22;
            lo  = base;
            mid = lo + $urandom_range(1, 1 << $urandom_range(0, 20));
            hi  = mid + $urandom_range(1, 1 << $urandom_range(0, 20));
        end else if (m <= 7) begin
            // wide bands from three sorted random edges
            lo  = base;
            mid = longint'($signed($urandom));
            hi  = longint'($signed($urandom));
            if (lo > mid) begin t = lo; lo = mid; mid = t; end
            if (mid > hi) begin t = mid; mid = hi; hi = t; end
            if (lo > mid) begin t = lo; lo = mid; mid = t; end
        end else if (m == 8) begin
            // bands of one or two units
            if (base > VAL_MAX - 4)
                base -= 4;
            lo  = base;
            mid = lo + $urandom_range(1, 2);
            hi  = mid + $urandom_range(1, 2);
        end else begin
            // out of order: a repeated edge or a reversed pair
            lo  = base;
            mid = $urandom_range(0, 1) ? lo : longint'($signed($urandom));
            hi  = $urandom_range(0, 1) ? mid : longint'($signed($urandom));
        end
        s = clamp_value(lo);
        g = clamp_value(mid);
        h = clamp_value(hi);
    endtask

    // sender: bursts of random length, random gaps, and every so often a
    // full drain where nothing is offered until all words have come back
    always @(negedge i_clk) begin : sample_driver
        logic             nv;
        logic [VAL_W-1:0] nd;
        nv = s_tvalid;
        nd = s_tdata;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!s_tvalid || sample_taken) begin
            nv = 1'b0;
            if (draining) begin
                if (band_expect.size() == 0)
                    draining = 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending_samples.size() != 0) begin
                nv = 1'b1;
                nd = pending_samples.pop_front();
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    // a quarter of bursts follow on with no gap at all
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    burst_no++;
                    if (burst_no % 16 == 5)
                        draining = 1'b1;
                end
            end
        end
        s_tvalid <= nv;
        s_tdata  <= nd;
    end

    // receiver: stretches of always-ready, coin-flip, mostly-stalled and stopped
    always @(negedge i_clk) begin : result_stall
        logic nr;
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = (ready_mode == 3) ? $urandom_range(1, 30) : $urandom_range(16, 80);
        end
        mode_left--;
        case (ready_mode)
            0:       nr = 1'b1;
            1:       nr = 1'($urandom_range(0, 1));
            2:       nr = ($urandom_range(0, 7) == 0);
            default: nr = 1'b0;
        endcase
        m_tready <= nr;
    end

    // edge registers as the block should hold them; index 3 is dropped
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            edge_safe <= SAFE_RST;
            edge_gold <= GOLD_RST;
            edge_hard <= HARD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SAFE: edge_safe <= i_cfg_data;
                REG_GOLD: edge_gold <= i_cfg_data;
                REG_HARD: edge_hard <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // monitor: check each result word against the oldest prediction,
    // then predict for any sample word taken at this edge
    always @(posedge i_clk) begin : word_monitor
        t_band_word want;
        sample_taken = i_rst_n && s_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_tready) begin
            if (band_expect.size() == 0) begin
                report_mismatch("arrived with nothing pending", 0, m_axis_tdata);
            end else begin
                want = band_expect.pop_front();
                if (m_axis_tdata !== OUT_W'(want.fraction))
                    report_mismatch("fraction", want.fraction, m_axis_tdata);
                if (m_axis_tuser[1:0] !== want.zone)
                    report_mismatch("zone", want.zone, m_axis_tuser[1:0]);
                if (m_axis_tuser[2] !== want.band_error)
                    report_mismatch("band_error", want.band_error, m_axis_tuser[2]);
            end
            words_out++;
        end
        if (sample_taken)
            band_expect.push_back(band_position(s_tdata));
    end

    // stimulus and end of run
    initial begin : stimulus
        logic [VAL_W-1:0] s, g, h;
        int               n;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset edges: range extremes, each edge and its neighbors, mid-segments
        pending_samples = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd0, 32'd1,
                            32'd32768, 32'd65535, 32'd65536, 32'd65537, 32'd98304,
                            32'd131071, 32'd131072, 32'd131073};
        wait_drained();

        // widest legal bands, spans close to 2^31 each
        write_bands(32'h8000_0000, 32'h0000_0000, 32'h7fff_ffff);
        pending_samples = '{32'h8000_0000, 32'h8000_0001, 32'hffff_ffff, 32'd0, 32'd1,
                            32'h7fff_fffe, 32'h7fff_ffff};
        wait_drained();

        // gold equal to safe, plus a stray write to the unused index
        write_band_edge(REG_UNUSED, $urandom);
        write_band_edge(REG_GOLD, 32'h8000_0000);
        pending_samples = '{32'd0, 32'h7fff_ffff, 32'h8000_0000};
        wait_drained();

        // hard below gold while safe is still lowest
        write_band_edge(REG_GOLD, 32'd0);
        write_band_edge(REG_HARD, 32'hffff_fffb);
        pending_samples = '{32'hffff_fffa, 32'd5};
        wait_drained();

        // random phases, each with new edges and a random run of samples
        while (random_sent < 600) begin
            pick_band_edges(s, g, h);
            write_bands(s, g, h);
            n = $urandom_range(30, 90);
            repeat (n)
                pending_samples.push_back(band_sample());
            random_sent += n;
            wait_drained();
        end

        // leave room for any stray word
        repeat (40) @(posedge i_clk);
        if (band_expect.size() != 0)
            report_mismatch("words never arrived", band_expect.size(), 0);
        if (mismatch_count == 0)
            $display("corridor_band_normalizer regression: pass");
        else
            $display("corridor_band_normalizer regression: fail");
        $finish;
    end

    // run limit, far above the slowest legal run
    initial begin : run_limit
        #5_000_000;
        $display("corridor_band_normalizer regression: fail");
        $finish;
    end

endmodule
